@@ src/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the frame receive checker
// Holds the request and result codes, the CRC constants and the result record
// passed from the frame tracker to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  // Default payload capacity of one frame
  localparam int MAX_PAYLOAD_DEF = 128;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS        = 1'd1;
  localparam logic [7:0] EXPECTED_ADDRESS_RST = 8'd1;
  localparam logic [7:0] GAP_TICKS_RST        = 8'd3;

  // Request kinds on the input stream
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result kinds on the output stream
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
  localparam logic [2:0] ST_BAD_ADDRESS  = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH   = 3'd3;
  localparam logic [2:0] ST_BAD_CRC      = 3'd4;

  // CRC-16 Modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Header bytes before the payload, and header plus trailer
  localparam logic [7:0] HEADER_BYTES   = 8'd4;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd6;

  // Output data packing
  localparam int TDATA_W = 48;

  typedef struct packed {
    logic        produce;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [6:0]  byte_index;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic        last;
  } frc_result_t;

endpackage

`default_nettype wire

@@ src/frc_crc_step.sv @@
// ----------------------------------------------------------------------------
// frc_crc_step: one byte of CRC-16 Modbus
// Folds one byte into a running reflected CRC, eight bit steps unrolled.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_crc_step
  import frc_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);

  // Shift out eight bits, applying the polynomial on each set low bit
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

@@ src/frc_frame_track.sv @@
// ----------------------------------------------------------------------------
// frc_frame_track: frame state and result generation
// Tracks header, byte count, idle ticks and running CRC, and forms the payload
// byte or end-of-frame verdict caused by the request being processed.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_frame_track
  import frc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic        req_type,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  expected_address,
  input  wire logic [7:0]  gap_ticks,
  output frc_result_t      result
);

  localparam logic [7:0] CAPACITY  = 8'(MAX_PAYLOAD + 6);
  localparam logic [7:0] PAY_LIMIT = 8'(MAX_PAYLOAD);

  logic        frame_active, frame_active_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  idle_count, idle_count_next;
  logic [7:0]  header_address, header_address_next;
  logic [7:0]  header_command, header_command_next;
  logic [15:0] header_length, header_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] trailing_bytes, trailing_bytes_next;

  // Frame state as seen by a byte: cleared when no frame is open
  logic [7:0]  cur_count;
  logic [7:0]  cur_address;
  logic [7:0]  cur_command;
  logic [15:0] cur_length;
  logic [15:0] cur_crc;
  logic [15:0] cur_trail;
  logic [15:0] crc_fed;

  assign cur_count   = frame_active ? byte_count     : 8'd0;
  assign cur_address = frame_active ? header_address : 8'd0;
  assign cur_command = frame_active ? header_command : 8'd0;
  assign cur_length  = frame_active ? header_length  : 16'd0;
  assign cur_crc     = frame_active ? running_crc    : CRC_INIT;
  assign cur_trail   = frame_active ? trailing_bytes : 16'd0;

  // Feed the byte leaving the trailer window into the CRC
  frc_crc_step u_crc (
    .crc_in  (cur_crc),
    .data_in (cur_trail[15:8]),
    .crc_out (crc_fed)
  );

  // Work out next state and the result of this request
  always_comb begin
    logic [7:0]  idle_inc;
    logic [7:0]  pay_idx;
    logic [16:0] want_count;
    logic [2:0]  verdict;

    frame_active_next   = frame_active;
    byte_count_next     = byte_count;
    idle_count_next     = idle_count;
    header_address_next = header_address;
    header_command_next = header_command;
    header_length_next  = header_length;
    running_crc_next    = running_crc;
    trailing_bytes_next = trailing_bytes;
    result              = '0;

    idle_inc   = (idle_count == 8'hFF) ? idle_count : idle_count + 8'd1;
    pay_idx    = cur_count - HEADER_BYTES;
    want_count = {1'b0, header_length} + 17'(FRAME_OVERHEAD);

    if (byte_count < FRAME_OVERHEAD) begin
      verdict = ST_TOO_SHORT;
    end else if (header_address != expected_address) begin
      verdict = ST_BAD_ADDRESS;
    end else if ({9'd0, byte_count} != want_count) begin
      verdict = ST_BAD_LENGTH;
    end else if (running_crc != trailing_bytes) begin
      verdict = ST_BAD_CRC;
    end else begin
      verdict = ST_OK;
    end

    if (fire) begin
      if (req_type == REQ_BYTE) begin
        // Open a frame if none is active, then take the byte unless full
        frame_active_next   = 1'b1;
        byte_count_next     = cur_count;
        idle_count_next     = frame_active ? idle_count : 8'd0;
        header_address_next = cur_address;
        header_command_next = cur_command;
        header_length_next  = cur_length;
        running_crc_next    = cur_crc;
        trailing_bytes_next = cur_trail;
        if (cur_count < CAPACITY) begin
          idle_count_next     = 8'd0;
          trailing_bytes_next = {cur_trail[7:0], data_byte};
          byte_count_next     = cur_count + 8'd1;
          if (cur_count >= 8'd2) begin
            running_crc_next = crc_fed;
          end
          case (cur_count)
            8'd0:    header_address_next = data_byte;
            8'd1:    header_command_next = data_byte;
            8'd2:    header_length_next  = {data_byte, 8'd0};
            8'd3:    header_length_next  = {cur_length[15:8], data_byte};
            default: header_length_next  = cur_length;
          endcase
          // Pass out a payload byte inside the declared length
          if (cur_count >= HEADER_BYTES && {8'd0, pay_idx} < cur_length &&
              pay_idx < PAY_LIMIT) begin
            result.produce      = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = data_byte;
            result.byte_index   = pay_idx[6:0];
          end
        end
      end else if (frame_active) begin
        // Count idle ticks; close the frame when the gap is reached
        idle_count_next = idle_inc;
        if (idle_inc >= gap_ticks) begin
          result.produce        = 1'b1;
          result.kind           = KIND_VERDICT;
          result.status         = verdict;
          result.command        = header_command;
          result.payload_length = header_length;
          result.last           = 1'b1;
          frame_active_next     = 1'b0;
          byte_count_next       = 8'd0;
          idle_count_next       = 8'd0;
          header_address_next   = 8'd0;
          header_command_next   = 8'd0;
          header_length_next    = 16'd0;
          running_crc_next      = CRC_INIT;
          trailing_bytes_next   = 16'd0;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active   <= 1'b0;
      byte_count     <= 8'd0;
      idle_count     <= 8'd0;
      header_address <= 8'd0;
      header_command <= 8'd0;
      header_length  <= 16'd0;
      running_crc    <= CRC_INIT;
      trailing_bytes <= 16'd0;
    end else begin
      frame_active   <= frame_active_next;
      byte_count     <= byte_count_next;
      idle_count     <= idle_count_next;
      header_address <= header_address_next;
      header_command <= header_command_next;
      header_length  <= header_length_next;
      running_crc    <= running_crc_next;
      trailing_bytes <= trailing_bytes_next;
    end
  end

endmodule

`default_nettype wire

@@ src/frame_receive_checker.sv @@
// Each request is held in an input register and its result then in the output register.
// One request per cycle while not stalled; the CRC byte step is a single unrolled stage.
// A full output register that is not taken stalls the input after one more request.
// Reset (rst, synchronous): no frame open, CRC 0xFFFF, expected_address 1,
// gap_ticks 3, both streams empty.
// ----------------------------------------------------------------------------
// frame_receive_checker: serial frame receiver with CRC-16 Modbus check
// Registers each request, runs it through the frame tracker and registers the
// payload byte or verdict it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_receive_checker
  import frc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]            s_tuser,   // [0] req_type
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [TDATA_W-1:0]         m_tdata,   // [7:0] payload_byte, [14:8] byte_index,
                                                // [17:15] status, [25:18] command,
                                                // [41:26] payload_length, [47:42] zero
  output logic [0:0]                 m_tuser,   // [0] kind
  output logic                       m_tlast,   // last
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        in_valid;
  logic        in_type;
  logic [7:0]  in_byte;
  logic        fire;
  logic        out_valid;
  logic [7:0]  expected_address;
  logic [7:0]  gap_ticks;
  frc_result_t res;
  frc_result_t out_res;

  // Process the held request once the output register can take its result
  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= EXPECTED_ADDRESS_RST;
      gap_ticks        <= GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_ADDRESS: expected_address <= cfg_data;
        REG_GAP_TICKS:        gap_ticks        <= cfg_data;
        default:              expected_address <= expected_address;
      endcase
    end
  end

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  frc_frame_track #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_track (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .req_type         (in_type),
    .data_byte        (in_byte),
    .expected_address (expected_address),
    .gap_ticks        (gap_ticks),
    .result           (res)
  );

  // Load the result register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res.produce;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.produce) begin
      out_res <= res;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {6'd0, out_res.payload_length, out_res.command, out_res.status,
                       out_res.byte_index, out_res.payload_byte};
  assign m_tuser[0] = out_res.kind;
  assign m_tlast    = out_res.last;

endmodule

`default_nettype wire

@@ src/frc_checker.sv @@
// ----------------------------------------------------------------------------
// frc_checker: port-level checks for the frame receive checker
// Watches both streams over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_checker
  import frc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic [0:0]         m_tuser,
  input wire logic               m_tlast
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("stalled result changed");

  // Reset leaves the input open and the output empty
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> s_tready && !m_tvalid)
    else $error("bad state after reset");

  // The input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // A payload byte carries no verdict
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == KIND_PAYLOAD |-> !m_tlast && m_tdata[17:15] == ST_OK)
    else $error("payload byte carries verdict fields");

endmodule

bind frame_receive_checker frc_checker u_frc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
